FILE: rtl/core/radius_neighbor_graph_builder_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef RADIUS_NEIGHBOR_GRAPH_BUILDER_UNIT_DEFINES_SVH
`define RADIUS_NEIGHBOR_GRAPH_BUILDER_UNIT_DEFINES_SVH

// Clocked on i_clk, off while reset is asserted.
`define RNGB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked on i_clk, also checked through reset.
`define RNGB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/rngb_pkg.sv
package rngb_pkg;

    localparam int MAX_POINTS = 32;
    localparam int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int ROW_LIMIT  = (MAX_POINTS < 32) ? MAX_POINTS : 32;

    localparam int IDX_W      = 5;
    localparam int ROW_W      = 6;
    localparam int EXT_W      = 7;
    localparam int COORD_W    = 10;
    localparam int RADIUS_W   = 11;
    localparam int COUNT_W    = 6;
    localparam int R2_W       = 2 * RADIUS_W;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int D2_W       = 22;
    localparam int FRAC_W     = 4;
    localparam int SQRT_IN_W  = D2_W + 2 * FRAC_W;
    localparam int ROOT_W     = SQRT_IN_W / 2;
    localparam int WEIGHT_W   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(200);
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(28);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = CFG_IDX_W'(1);

    typedef struct packed {
        logic               opcode;
        logic [IDX_W-1:0]   point_index;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]    neighbor_index;
        logic                edge_present;
        logic [WEIGHT_W-1:0] edge_weight;
        logic                last_in_row;
    } t_res;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_point;

endpackage

FILE: rtl/core/rngb_point_mem.sv
module rngb_point_mem (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [rngb_pkg::AW-1:0] i_waddr,
    input  rngb_pkg::t_point     i_wdata,
    input  logic [rngb_pkg::AW-1:0] i_raddr,
    output rngb_pkg::t_point     o_rdata
);
    import rngb_pkg::*;

    t_point r_mem [MAX_POINTS];
    t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/rngb_isqrt.sv
module rngb_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rngb_pkg::SQRT_IN_W-1:0] i_radicand,
    output logic                         o_done,
    output logic [rngb_pkg::ROOT_W-1:0]  o_root
);
    import rngb_pkg::*;

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);

    logic                 r_run;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [SQRT_IN_W-1:0] r_rad;
    logic [REM_W-1:0]     r_rem;
    logic [ROOT_W-1:0]    r_root;

    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic                 fits;
    logic [REM_W-1:0]     n_rem;
    logic [ROOT_W-1:0]    n_root;

    // one root bit per cycle, two radicand bits brought down each step
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[SQRT_IN_W-1 -: 2]};
        trial  = REM_W'({r_root, 2'b01});
        fits   = (rem_sh >= trial);
        n_rem  = fits ? (rem_sh - trial) : rem_sh;
        n_root = {r_root[ROOT_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(ROOT_W - 1);
            end else if (r_run) begin
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_rad  <= {r_rad[SQRT_IN_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: rtl/core/radius_neighbor_graph_builder_unit.sv
// Fixed-radius neighbor graph over a table of up to 32 points.
// Command channel: a transaction is taken when start is high and busy is low.
// A write command stores (coord_x, coord_y) at point_index and is done at once;
// busy stays low. A query command for point m walks j = 0 .. row length - 1,
// row length being point_count capped at the table depth, and emits one
// result per j on o_res, marked by o_res_strobe for one cycle. The receiver
// has no back-pressure: every strobe cycle is one delivered result.
// Per neighbor the walk reads the point, forms the differences, then the
// squares, then compares; an edge adds a pass through the one-bit-per-cycle
// square root unit before its result strobes. busy drops in
// the cycle the last result strobes. Point coordinates sit in a one-port
// write, one-port read memory with registered read data.
// Configuration writes (radius, point_count) are taken in any cycle; a query
// runs on the values present when it was accepted. Reset returns the
// registers to radius 200 and point_count 28 and aborts any query; the point
// table is not cleared.
module radius_neighbor_graph_builder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  rngb_pkg::t_cmd                  i_cmd,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rngb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rngb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_res_strobe,
    output rngb_pkg::t_res                  o_res
);
    import rngb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LDM  = 3'd1;
    localparam logic [2:0] S_DIFF = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_ROOT = 3'd5;

    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_POINTS);
    localparam logic [ROW_W-1:0] ROW_CAP = ROW_W'(ROW_LIMIT);

    logic [2:0]          r_state, n_state;
    logic [ROW_W-1:0]    r_j, n_j;
    logic [RADIUS_W-1:0] r_radius;
    logic [COUNT_W-1:0]  r_count;
    logic [R2_W-1:0]     r_r2;
    logic [ROW_W-1:0]    r_n;
    logic [IDX_W-1:0]    r_m;
    logic                r_m_valid;
    t_point              r_mpt;
    logic [COORD_W-1:0]  r_dx, r_dy;
    logic [SQ_W-1:0]     r_sx, r_sy;
    logic                r_res_strobe;
    t_res                r_res;

    logic                cmd_acc;
    logic                m_ok;
    logic [ROW_W-1:0]    m_ext;
    logic [ROW_W-1:0]    row_len;
    logic                mem_we;
    logic [AW-1:0]       rd_addr;
    t_point              rd_data;
    t_point              wr_data;
    logic [D2_W-1:0]     d2;
    logic                edge_hit;
    logic                last_j;
    logic                emit;
    logic                emit_edge;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cmd_acc     = i_rst_n && start && (r_state == S_IDLE);
    assign m_ext       = ROW_W'(i_cmd.point_index);
    assign m_ok        = (EXT_W'(i_cmd.point_index) < MAX_EXT);
    assign row_len     = (ROW_W'(r_count) < ROW_CAP) ? ROW_W'(r_count) : ROW_CAP;
    assign mem_we      = cmd_acc && (i_cmd.opcode == OP_WRITE) && m_ok;
    assign wr_data     = '{x: i_cmd.coord_x, y: i_cmd.coord_y};
    assign rd_addr     = (r_state == S_IDLE) ? m_ext[AW-1:0] : n_j[AW-1:0];

    assign d2       = D2_W'(r_sx) + D2_W'(r_sy);
    assign edge_hit = r_m_valid && (r_j != ROW_W'(r_m)) && (d2 < r_r2);
    assign last_j   = ((r_j + ROW_W'(1)) == r_n);

    rngb_point_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (m_ext[AW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    rngb_isqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand ({d2, {(2 * FRAC_W){1'b0}}}),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        emit       = 1'b0;
        emit_edge  = 1'b0;
        sqrt_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_j = '0;
                if (cmd_acc && (i_cmd.opcode == OP_QUERY) && (row_len != '0)) begin
                    n_state = S_LDM;
                end
            end
            S_LDM:  n_state = S_DIFF;
            S_DIFF: n_state = S_SQ;
            S_SQ:   n_state = S_SUM;
            S_SUM: begin
                if (edge_hit) begin
                    sqrt_start = 1'b1;
                    n_state    = S_ROOT;
                end else begin
                    emit = 1'b1;
                end
            end
            S_ROOT: begin
                if (sqrt_done) begin
                    emit      = 1'b1;
                    emit_edge = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // emitting cycle also issues the read of the next point
        if (emit) begin
            if (last_j) begin
                n_state = S_IDLE;
                n_j     = '0;
            end else begin
                n_state = S_DIFF;
                n_j     = r_j + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_j          <= '0;
            r_radius     <= RADIUS_RESET;
            r_count      <= COUNT_RESET;
            r_res_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_j          <= n_j;
            r_res_strobe <= emit;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_RADIUS: r_radius <= i_cfg_data[RADIUS_W-1:0];
                    CFG_COUNT:  r_count  <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_r2      <= R2_W'(r_radius) * R2_W'(r_radius);
            r_n       <= row_len;
            r_m       <= i_cmd.point_index;
            r_m_valid <= m_ok;
        end
        if (r_state == S_LDM) begin
            r_mpt <= rd_data;
        end
        if (r_state == S_DIFF) begin
            r_dx <= (r_mpt.x > rd_data.x) ? (r_mpt.x - rd_data.x) : (rd_data.x - r_mpt.x);
            r_dy <= (r_mpt.y > rd_data.y) ? (r_mpt.y - rd_data.y) : (rd_data.y - r_mpt.y);
        end
        if (r_state == S_SQ) begin
            r_sx <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_sy <= SQ_W'(r_dy) * SQ_W'(r_dy);
        end
        if (emit) begin
            r_res.neighbor_index <= r_j[IDX_W-1:0];
            r_res.edge_present   <= emit_edge;
            r_res.edge_weight    <= emit_edge ? WEIGHT_W'(sqrt_root) : '0;
            r_res.last_in_row    <= last_j;
        end
    end

    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

endmodule

FILE: rtl/core/rngb_checker.sv
`include "radius_neighbor_graph_builder_unit_defines.svh"

module rngb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_res_strobe,
    input rngb_pkg::t_res o_res
);
    import rngb_pkg::*;

    // a row only starts from a taken command
    `RNGB_ASSERT(a_busy_from_start, $rose(busy) |-> $past(start), "busy rose without start")

    // results never strobe back to back
    `RNGB_ASSERT(a_strobe_spaced, o_res_strobe |=> !o_res_strobe, "back-to-back result strobes")

    // the row's last result is the one that frees the block
    `RNGB_ASSERT(a_last_frees, o_res_strobe |-> (busy != o_res.last_in_row), "last_in_row and busy disagree")

    // no weight without an edge
    `RNGB_ASSERT(a_weight_zero, (o_res_strobe && !o_res.edge_present) |-> (o_res.edge_weight == '0), "weight on a non-edge")

    `RNGB_ASSERT_RST(a_rst_quiet, !i_rst_n |=> !o_res_strobe, "result strobe after reset")

endmodule

bind radius_neighbor_graph_builder_unit rngb_checker u_rngb_checker (.*);

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rngb_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int CFG_SETTLE  = 8;
    localparam int END_SETTLE  = 40;
    localparam int PRINT_CAP   = 40;
    localparam int COORD_MAX   = 2**COORD_W - 1;
    localparam int RADIUS_MAX  = 2**RADIUS_W - 1;

    // register indexes with nothing behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = CFG_IDX_W'(3);

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_cmd                  i_cmd       = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_res_strobe;
    t_res                  o_res;

    // local copy of the point table and the registers
    logic [COORD_W-1:0]  pt_x [MAX_POINTS];
    logic [COORD_W-1:0]  pt_y [MAX_POINTS];
    logic [RADIUS_W-1:0] radius_now = RADIUS_RESET;
    logic [COUNT_W-1:0]  count_now  = COUNT_RESET;

    t_res neighbor_q [$];
    t_res want;

    int errors       = 0;
    int cycle_count  = 0;
    int writes_sent  = 0;
    int queries_sent = 0;
    int reg_writes   = 0;
    int results_seen = 0;
    int edges_seen   = 0;

    radius_neighbor_graph_builder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, neighbor_q.size());
            $display("radius_neighbor_graph_builder_unit regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // floor(sqrt(v)), one result bit per step from the top
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic void predict_neighbor_row(logic [IDX_W-1:0] m);
        int unsigned     row_len;
        longint unsigned dx, dy, d2, r2;
        t_res            r;
        row_len = (count_now > ROW_LIMIT) ? ROW_LIMIT : count_now;
        r2 = radius_now;
        r2 = r2 * r2;
        for (int j = 0; j < row_len; j++) begin
            dx = (pt_x[m] > pt_x[j]) ? pt_x[m] - pt_x[j] : pt_x[j] - pt_x[m];
            dy = (pt_y[m] > pt_y[j]) ? pt_y[m] - pt_y[j] : pt_y[j] - pt_y[m];
            d2 = dx * dx + dy * dy;
            r.neighbor_index = IDX_W'(j);
            r.edge_present   = (j != int'(m)) && (d2 < r2);
            r.edge_weight    = r.edge_present ? WEIGHT_W'(floor_root(d2 << 8)) : '0;
            r.last_in_row    = (j == int'(row_len) - 1);
            neighbor_q.push_back(r);
        end
    endfunction

    function automatic t_cmd make_cmd(logic op, int idx, int x, int y);
        t_cmd c;
        c.opcode      = op;
        c.point_index = IDX_W'(idx);
        c.coord_x     = COORD_W'(x);
        c.coord_y     = COORD_W'(y);
        return c;
    endfunction

    function automatic logic [COORD_W-1:0] near(int c);
        int v;
        v = c + int'($urandom_range(300)) - 150;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return COORD_W'(v);
    endfunction

    // mostly clustered points so that rows carry edges; some uniform, some on the border
    task automatic random_point(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
        int unsigned mode;
        mode = $urandom_range(9);
        if (mode < 6) begin
            case (mode % 3)
                0: begin
                    x = near(100);
                    y = near(120);
                end
                1: begin
                    x = near(512);
                    y = near(600);
                end
                default: begin
                    x = near(930);
                    y = near(880);
                end
            endcase
        end else if (mode < 8) begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end else begin
            x = $urandom_range(1) ? COORD_W'(COORD_MAX) : '0;
            y = $urandom_range(1) ? COORD_W'(COORD_MAX) : '0;
        end
    endtask

    // start is left high; whoever idles next lowers it
    task automatic send_cmd(t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (c.opcode == OP_WRITE) begin
            pt_x[c.point_index] = c.coord_x;
            pt_y[c.point_index] = c.coord_y;
            writes_sent++;
        end else begin
            predict_neighbor_row(c.point_index);
            queries_sent++;
        end
    endtask

    task automatic sender_pause(int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            i_cmd <= make_cmd(1'($urandom_range(1)), $urandom, $urandom, $urandom);
            @(posedge i_clk);
        end
    endtask

    task automatic drain_block(int settle);
        start <= 1'b0;
        while (neighbor_q.size() != 0 || busy) @(posedge i_clk);
        // an empty row gives no result to wait on
        repeat (settle) @(posedge i_clk);
    endtask

    // valid is left high; the caller lowers it after its last transaction
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        logic [CFG_DATA_W-1:0] bits;
        bits = CFG_DATA_W'(data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= bits;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_RADIUS: radius_now = bits[RADIUS_W-1:0];
            CFG_COUNT:  count_now  = bits[COUNT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_config(int r, int n);
        drain_block(CFG_SETTLE);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_COUNT, n);
        i_cfg_valid <= 1'b0;
    endtask

    // whole table filled, rows checked under the register values after reset
    task automatic test_reset_values();
        logic [COORD_W-1:0] x, y;
        for (int i = 0; i < MAX_POINTS; i++) begin
            random_point(x, y);
            send_cmd(make_cmd(OP_WRITE, i, int'(x), int'(y)));
        end
        send_cmd(make_cmd(OP_QUERY, 0, COORD_MAX, COORD_MAX));
        send_cmd(make_cmd(OP_QUERY, 27, 0, 0));
        send_cmd(make_cmd(OP_QUERY, MAX_POINTS - 1, 0, COORD_MAX));
        drain_block(CFG_SETTLE);
    endtask

    task automatic test_distance_threshold();
        apply_config(6, 4);
        send_cmd(make_cmd(OP_WRITE, 0, 0, 0));
        send_cmd(make_cmd(OP_WRITE, 1, 3, 4));
        send_cmd(make_cmd(OP_WRITE, 2, 0, 0));
        send_cmd(make_cmd(OP_WRITE, 3, COORD_MAX, COORD_MAX));
        send_cmd(make_cmd(OP_QUERY, 0, 0, 0));
        send_cmd(make_cmd(OP_QUERY, 1, 0, 0));
        // distance equal to the radius is not an edge
        apply_config(5, 4);
        send_cmd(make_cmd(OP_QUERY, 0, 0, 0));
        apply_config(0, 4);
        send_cmd(make_cmd(OP_QUERY, 2, 0, 0));
        // coincident points link with weight zero
        apply_config(1, 4);
        send_cmd(make_cmd(OP_QUERY, 2, 0, 0));
        // corner to corner, largest weight
        apply_config(RADIUS_MAX, 4);
        send_cmd(make_cmd(OP_QUERY, 3, 0, 0));
        drain_block(CFG_SETTLE);
    endtask

    task automatic test_row_length();
        apply_config(1500, 1);
        send_cmd(make_cmd(OP_QUERY, 0, 0, 0));
        // queried point sits past the end of the row
        apply_config(1500, 2);
        send_cmd(make_cmd(OP_QUERY, 3, 0, 0));
        apply_config(1500, 0);
        send_cmd(make_cmd(OP_QUERY, 5, 0, 0));
        // count above the table depth is capped
        apply_config(1500, 63);
        send_cmd(make_cmd(OP_WRITE, MAX_POINTS - 1, COORD_MAX, 0));
        send_cmd(make_cmd(OP_QUERY, MAX_POINTS - 1, 0, 0));
        apply_config(200, ROW_LIMIT);
        send_cmd(make_cmd(OP_QUERY, 30, COORD_MAX, 0));
        drain_block(CFG_SETTLE);
    endtask

    task automatic test_config_port();
        drain_block(CFG_SETTLE);
        write_reg(CFG_RADIUS, 1365);
        write_reg(CFG_COUNT, 21);
        write_reg(CFG_UNMAPPED_A, $urandom);
        write_reg(CFG_UNMAPPED_B, $urandom);
        i_cfg_valid <= 1'b0;
        send_cmd(make_cmd(OP_QUERY, 10, 0, 0));
        send_cmd(make_cmd(OP_QUERY, 20, 0, 0));
        apply_config(682, 42);
        send_cmd(make_cmd(OP_QUERY, 7, 0, 0));
        drain_block(CFG_SETTLE);
    endtask

    task automatic test_random_traffic(int pct, int total);
        int                 done, seg, sel;
        int                 r, n;
        logic [COORD_W-1:0] x, y;
        done = 0;
        while (done < total) begin
            sel = $urandom_range(9);
            r = (sel == 0) ? 0 :
                (sel == 1) ? RADIUS_MAX :
                (sel < 6)  ? int'($urandom_range(400, 50)) :
                (sel < 8)  ? int'($urandom_range(RADIUS_MAX, 1)) : 200;
            sel = $urandom_range(9);
            n = (sel == 0) ? ROW_LIMIT :
                (sel == 1) ? 1 :
                (sel == 2) ? int'($urandom_range(63, 33)) : int'($urandom_range(ROW_LIMIT, 2));
            apply_config(r, n);
            seg = $urandom_range(45, 25);
            for (int k = 0; k < seg && done < total; k++) begin
                sender_pause(pct);
                if ($urandom_range(99) < 40) begin
                    random_point(x, y);
                    send_cmd(make_cmd(OP_WRITE, $urandom_range(MAX_POINTS - 1),
                                      int'(x), int'(y)));
                end else begin
                    send_cmd(make_cmd(OP_QUERY, $urandom_range(MAX_POINTS - 1),
                                      $urandom, $urandom));
                end
                done++;
            end
        end
        drain_block(CFG_SETTLE);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            results_seen++;
            if (neighbor_q.size() == 0) begin
                report_mismatch($sformatf("result for neighbor %0d with no query pending",
                                          o_res.neighbor_index));
            end else begin
                want = neighbor_q.pop_front();
                if (want.edge_present) edges_seen++;
                if (o_res.neighbor_index !== want.neighbor_index)
                    report_mismatch($sformatf("neighbor_index %0d, expected %0d",
                                              o_res.neighbor_index, want.neighbor_index));
                if (o_res.edge_present !== want.edge_present)
                    report_mismatch($sformatf("edge_present %0b, expected %0b at neighbor %0d",
                                              o_res.edge_present, want.edge_present,
                                              want.neighbor_index));
                if (o_res.edge_weight !== want.edge_weight)
                    report_mismatch($sformatf("edge_weight %0d, expected %0d at neighbor %0d",
                                              o_res.edge_weight, want.edge_weight,
                                              want.neighbor_index));
                if (o_res.last_in_row !== want.last_in_row)
                    report_mismatch($sformatf("last_in_row %0b, expected %0b at neighbor %0d",
                                              o_res.last_in_row, want.last_in_row,
                                              want.neighbor_index));
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_distance_threshold();
        test_row_length();
        test_config_port();
        test_random_traffic(34, 119);
        test_random_traffic(86, 119);
        test_random_traffic(0, 118);

        drain_block(END_SETTLE);
        if (neighbor_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", neighbor_q.size()));

        $display("covered %0d point writes, %0d row queries, %0d register writes",
                 writes_sent, queries_sent, reg_writes);
        $display("checked %0d neighbor results, %0d carrying an edge; %0d mismatches",
                 results_seen, edges_seen, errors);
        if (errors == 0) begin
            $display("radius_neighbor_graph_builder_unit regression: pass");
        end else begin
            $display("radius_neighbor_graph_builder_unit regression: fail");
        end
        $finish;
    end

endmodule
